### src/mvsm_pkg.sv
package mvsm_pkg;

  localparam int VOICES       = 8;
  localparam int SAMPLE_WORDS = 4096;

  localparam int ADDR_W   = $clog2(SAMPLE_WORDS);
  localparam int VIDX_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W    = $clog2(VOICES + 1);
  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 13;
  localparam int GAIN_W   = 9;
  localparam int PROD_W   = SAMPLE_W + GAIN_W;
  localparam int SCALE_W  = SAMPLE_W + 1;
  localparam int SUM_W    = SCALE_W + VIDX_W + 1;

  localparam logic [LEN_W-1:0]  MAX_LEN    = LEN_W'(4096);
  localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(256);

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_code_t;

  typedef struct packed {
    logic              accept;
    logic              scan;
    logic [VIDX_W-1:0] idx;
    logic              load_out;
  } dp_ctl_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

### src/mvsm_ctrl.sv
module mvsm_ctrl
  import mvsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_cmd,
  output logic       in_ready,
  input  dp_stat_t   st,
  output dp_ctl_t    ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN1,
    S_DRAIN2,
    S_POST
  } state_t;

  state_t            state_r, state_nxt;
  logic [VIDX_W-1:0] idx_r, idx_nxt;
  logic              accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_cmd == CMD_TICK) begin
          state_nxt = S_SCAN;
          idx_nxt   = '0;
        end
      end
      S_SCAN: begin
        if (idx_r == VIDX_W'(VOICES - 1)) begin
          state_nxt = S_DRAIN1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DRAIN1: state_nxt = S_DRAIN2;
      S_DRAIN2: state_nxt = S_POST;
      S_POST: begin
        // hold the finished sum until the output register frees up
        if (st.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.accept   = accept;
    ctl.scan     = (state_r == S_SCAN);
    ctl.idx      = idx_r;
    ctl.load_out = (state_r == S_POST) && st.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

### src/mvsm_dp.sv
module mvsm_dp
  import mvsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  dp_ctl_t            ctl,
  output dp_stat_t           st,
  input  logic [1:0]         in_cmd,
  input  logic [11:0]        in_mem_addr,
  input  logic signed [15:0] in_load_value,
  input  logic [2:0]         in_voice_slot,
  input  logic [12:0]        in_sound_length,
  input  logic [8:0]         in_gain,
  input  logic               in_looped,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_mixed_sample,
  output logic               out_saturated,
  output logic [3:0]         out_voices_active
);

  logic signed [SAMPLE_W-1:0] mem [SAMPLE_WORDS];

  logic [VOICES-1:0] active_r;
  logic [VOICES-1:0] looped_r;
  logic [ADDR_W-1:0] base_r [VOICES];
  logic [LEN_W-1:0]  len_r  [VOICES];
  logic [ADDR_W-1:0] pos_r  [VOICES];
  logic [GAIN_W-1:0] gain_r [VOICES];

  logic                       act1_r, act2_r;
  logic signed [SAMPLE_W-1:0] rd_r;
  logic [GAIN_W-1:0]          gain1_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [CNT_W-1:0]           cnt_r;

  logic                       out_valid_r;
  logic signed [15:0]         mixed_r;
  logic                       sat_r;
  logic [3:0]                 cnt_out_r;

  logic                       do_load, do_start, do_tick;
  logic [VIDX_W-1:0]          slot;
  logic [LEN_W-1:0]           len_sat;
  logic [GAIN_W-1:0]          gain_sat;
  logic [ADDR_W-1:0]          rd_addr;
  logic [LEN_W-1:0]           pos_inc;
  logic                       at_end;
  logic                       still_active;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [SCALE_W-1:0]  scaled;
  logic signed [SUM_W-1:0]    sum_nxt;
  logic                       clip;
  logic signed [15:0]         mixed_nxt;

  assign do_load  = ctl.accept && in_cmd == CMD_LOAD;
  assign do_start = ctl.accept && in_cmd == CMD_START && int'(in_voice_slot) < VOICES;
  assign do_tick  = ctl.accept && in_cmd == CMD_TICK;
  assign slot     = in_voice_slot[VIDX_W-1:0];

  assign len_sat  = (in_sound_length > MAX_LEN) ? MAX_LEN : in_sound_length;
  assign gain_sat = (in_gain > UNITY_GAIN) ? UNITY_GAIN : in_gain;

  // per-voice read address and position step for the voice under scan
  assign rd_addr      = base_r[ctl.idx] + pos_r[ctl.idx];
  assign pos_inc      = {1'b0, pos_r[ctl.idx]} + 1'b1;
  assign at_end       = pos_inc >= len_r[ctl.idx];
  assign still_active = active_r[ctl.idx] && (looped_r[ctl.idx] || !at_end);

  // round toward zero: bias negative products before the arithmetic shift
  assign prod_nxt = PROD_W'(rd_r * $signed({1'b0, gain1_r}));
  always_comb begin
    if (prod_r < 0) begin
      scaled = SCALE_W'((prod_r + PROD_W'(255)) >>> 8);
    end else begin
      scaled = SCALE_W'(prod_r >>> 8);
    end
  end
  assign sum_nxt = sum_r + SUM_W'(scaled);

  always_comb begin
    clip      = 1'b0;
    mixed_nxt = sum_r[15:0];
    if (sum_r > SUM_W'(32767)) begin
      clip      = 1'b1;
      mixed_nxt = 16'sh7fff;
    end else if (sum_r < -SUM_W'(32768)) begin
      clip      = 1'b1;
      mixed_nxt = 16'sh8000;
    end
  end

  assign st.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (do_load) begin
      mem[in_mem_addr[ADDR_W-1:0]] <= in_load_value;
    end
    if (ctl.scan) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (do_start) begin
      base_r[slot]   <= in_mem_addr[ADDR_W-1:0];
      len_r[slot]    <= len_sat;
      gain_r[slot]   <= gain_sat;
      looped_r[slot] <= in_looped;
      pos_r[slot]    <= '0;
    end else if (ctl.scan && active_r[ctl.idx]) begin
      pos_r[ctl.idx] <= at_end ? '0 : pos_inc[ADDR_W-1:0];
    end
    gain1_r <= gain_r[ctl.idx];
    prod_r  <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      act1_r      <= 1'b0;
      act2_r      <= 1'b0;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_start) begin
        active_r[slot] <= (len_sat != '0);
      end else if (ctl.scan) begin
        active_r[ctl.idx] <= still_active;
      end
      act1_r <= ctl.scan && active_r[ctl.idx];
      act2_r <= act1_r;
      if (do_tick) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else begin
        if (act2_r) begin
          sum_r <= sum_nxt;
        end
        if (ctl.scan && still_active) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (ctl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      mixed_r   <= mixed_nxt;
      sat_r     <= clip;
      cnt_out_r <= 4'(cnt_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mixed_sample  = mixed_r;
  assign out_saturated     = sat_r;
  assign out_voices_active = cnt_out_r;

endmodule

### src/multi_voice_sample_mixer.sv
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_ready  | cmd, mem_addr, load_value, voice_slot,
//         |           |                    | sound_length, gain, looped
// out_    | output    | out_valid/out_ready| mixed_sample, saturated, voices_active
//
// Load and start items are done as they are accepted; a tick item scans the voices,
// one voice per cycle through the sample memory read port, then passes S_DRAIN1 and
// S_DRAIN2 to drain the read/multiply/accumulate pipe and S_POST to load the result.
// Synchronous active-low reset clears all voices; sample memory is not cleared.
// A waiting result does not block new load or start items; a tick stalls only in
// its last step until the output register is free.
module multi_voice_sample_mixer
  import mvsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [11:0]        in_mem_addr,
  input  logic signed [15:0] in_load_value,
  input  logic [2:0]         in_voice_slot,
  input  logic [12:0]        in_sound_length,
  input  logic [8:0]         in_gain,
  input  logic               in_looped,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_mixed_sample,
  output logic               out_saturated,
  output logic [3:0]         out_voices_active
);

  dp_ctl_t  ctl;
  dp_stat_t st;

  mvsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_ready (in_ready),
    .st       (st),
    .ctl      (ctl)
  );

  mvsm_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .st                (st),
    .in_cmd            (in_cmd),
    .in_mem_addr       (in_mem_addr),
    .in_load_value     (in_load_value),
    .in_voice_slot     (in_voice_slot),
    .in_sound_length   (in_sound_length),
    .in_gain           (in_gain),
    .in_looped         (in_looped),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_mixed_sample  (out_mixed_sample),
    .out_saturated     (out_saturated),
    .out_voices_active (out_voices_active)
  );

endmodule
